// ----- rtl/core/text_width_measure_defines.svh -----
// assertion macros shared by the text width measurement checker
`ifndef TEXT_WIDTH_MEASURE_DEFINES_SVH
`define TEXT_WIDTH_MEASURE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TWM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/twm_pkg.sv -----
// shared types, codes and constants of the text width measurement block
package twm_pkg;

  // default parameter values
  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int DEF_TAB_SPACES    = 5;
  localparam int DEF_ESCAPE_SKIP   = 4;
  localparam int DEF_WIDTH_BITS    = 24;

  // field widths
  localparam int CODE_BITS      = 8;
  localparam int GLYPH_W_BITS   = 12;
  localparam int SCALE_BITS     = 32;
  localparam int COUNT_BITS     = 16;
  localparam int UNITS_BITS     = 24;
  localparam int SCALED_BITS    = 56;
  localparam int IN_DATA_BITS   = 32;
  localparam int OUT_DATA_BITS  = 80;
  localparam int OUT_USER_BITS  = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 1;
  localparam int QUEUE_DEPTH    = 2;

  // character codes
  localparam logic [CODE_BITS-1:0] CODE_END   = 8'h00;
  localparam logic [CODE_BITS-1:0] CODE_ESC   = 8'h01;
  localparam logic [CODE_BITS-1:0] CODE_TAB   = 8'h09;
  localparam logic [CODE_BITS-1:0] CODE_NL    = 8'h0A;
  localparam logic [CODE_BITS-1:0] CODE_SPACE = 8'h20;

  // command codes carried in tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_SCALE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CHARS   = 1'b1;

  localparam logic [SCALE_BITS-1:0]  SCALE_RESET = 32'h0001_0000;
  localparam logic [UNITS_BITS-1:0]  UNITS_MAX   = 24'hFF_FFFF;
  localparam logic [SCALED_BITS-1:0] SCALED_MAX  = 56'hFF_FFFF_FFFF_FFFF;

  // class of a text byte
  typedef enum logic [2:0] {
    KIND_CHAR,
    KIND_TAB,
    KIND_NL,
    KIND_ESC,
    KIND_END
  } kind_t;

  // classified text word with its glyph data resolved
  typedef struct packed {
    kind_t                    kind;
    logic                     last;
    logic                     hit;
    logic [GLYPH_W_BITS-1:0]  glyph_width;
    logic [GLYPH_W_BITS-1:0]  glyph_advance;
    logic                     space_ok;
    logic [GLYPH_W_BITS-1:0]  space_width;
  } item_t;

  // one measurement result
  typedef struct packed {
    logic                    saturated;
    logic                    limit_hit;
    logic [SCALED_BITS-1:0]  width_scaled;
    logic [UNITS_BITS-1:0]   width_units;
  } result_t;

endpackage

// ----- rtl/core/text_width_measure.sv -----
// top level of the text width measurement block
// Measures the widest line of a text string streamed one byte per word, after the
// glyph table has been loaded with load words (tuser = 0). Loads and text bytes are
// taken at one word per cycle while s_tready is high; the front end registers a glyph
// table read for each text word and queues it for the line width engine. Ordinary
// bytes, colour code bytes and newlines are retired at one per cycle while idle. A
// tab with a usable space glyph runs the restoring divider, which finds the next tab
// stop one bit per cycle, and then the tab stop state. The end of a string or the
// character limit passes through result capture, scale multiply and result register
// before the result word appears; while the engine is busy the front end keeps taking
// words until its two-entry queue and the staging register in front of it are full.
// The result register lets the engine go on to the next string while a result waits
// to be taken. Register writes are expected only while the block is idle.
module text_width_measure #(
  parameter int TABLE_ENTRIES = twm_pkg::DEF_TABLE_ENTRIES,
  parameter int TAB_SPACES    = twm_pkg::DEF_TAB_SPACES,
  parameter int ESCAPE_SKIP   = twm_pkg::DEF_ESCAPE_SKIP,
  parameter int WIDTH_BITS    = twm_pkg::DEF_WIDTH_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [twm_pkg::IN_DATA_BITS-1:0]    s_tdata,   // code, glyph_width, glyph_advance
  input  logic                                s_tuser,   // cmd
  input  logic                                s_tlast,   // last
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [twm_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // width_units, width_scaled
  output logic [twm_pkg::OUT_USER_BITS-1:0]   m_tuser,   // limit_hit, saturated
  input  logic                                cfg_we,
  input  logic [twm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [twm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import twm_pkg::*;

  logic [SCALE_BITS-1:0] width_scale;
  logic [COUNT_BITS-1:0] max_chars;

  logic    push_valid;
  logic    push_ready;
  item_t   push_item;
  logic    q_valid;
  item_t   q_item;
  logic    pop;
  result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_scale <= SCALE_RESET;
      max_chars   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH_SCALE: width_scale <= cfg_wdata[SCALE_BITS-1:0];
        REG_MAX_CHARS:   max_chars   <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  twm_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  twm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop)
  );

  twm_back #(
    .TAB_SPACES  (TAB_SPACES),
    .ESCAPE_SKIP (ESCAPE_SKIP),
    .WIDTH_BITS  (WIDTH_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .width_scale (width_scale),
    .max_chars   (max_chars),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .res_valid   (m_tvalid),
    .res         (res),
    .res_ready   (m_tready)
  );

  // result word packing
  assign m_tdata = {res.width_scaled, res.width_units};
  assign m_tuser = {res.saturated, res.limit_hit};

endmodule

// ----- rtl/core/twm_front.sv -----
// front end: glyph table loads, text byte classification and table lookup
module twm_front #(
  parameter int TABLE_ENTRIES = twm_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [twm_pkg::IN_DATA_BITS-1:0]  s_tdata,   // code, glyph_width, glyph_advance
  input  logic                              s_tuser,   // cmd
  input  logic                              s_tlast,   // last
  output logic                              push_valid,
  output twm_pkg::item_t                    push_item,
  input  logic                              push_ready
);
  import twm_pkg::*;

  localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
  localparam int ENTRY_BITS = 2 * GLYPH_W_BITS;

  logic [ENTRY_BITS-1:0]   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;
  logic [ENTRY_BITS-1:0]   rd_data;
  logic                    rd_hit;

  logic                    space_valid;
  logic [GLYPH_W_BITS-1:0] space_width;

  logic                    s1_valid;
  kind_t                   s1_kind;
  logic                    s1_last;
  logic                    s1_space_ok;
  logic [GLYPH_W_BITS-1:0] s1_space_width;

  logic [CODE_BITS-1:0]    code;
  logic [GLYPH_W_BITS-1:0] gw;
  logic [GLYPH_W_BITS-1:0] ga;
  logic [IDX_BITS-1:0]     idx;
  logic                    in_range;
  logic                    accept;
  logic                    do_load;
  logic                    do_text;
  kind_t                   kind;

  assign code     = s_tdata[CODE_BITS-1:0];
  assign gw       = s_tdata[CODE_BITS +: GLYPH_W_BITS];
  assign ga       = s_tdata[CODE_BITS+GLYPH_W_BITS +: GLYPH_W_BITS];
  assign idx      = code[IDX_BITS-1:0];
  assign in_range = {1'b0, code} < (CODE_BITS+1)'(TABLE_ENTRIES);

  assign s_tready = !s1_valid || push_ready;
  assign accept   = s_tvalid && s_tready;
  assign do_load  = accept && (s_tuser == CMD_LOAD);
  assign do_text  = accept && (s_tuser == CMD_TEXT);

  // classify the byte
  always_comb begin
    unique case (code)
      CODE_END: kind = KIND_END;
      CODE_ESC: kind = KIND_ESC;
      CODE_TAB: kind = KIND_TAB;
      CODE_NL:  kind = KIND_NL;
      default:  kind = KIND_CHAR;
    endcase
  end

  // glyph table storage, one write or one registered read per accepted word
  always_ff @(posedge clk) begin
    if (do_load && in_range) begin
      mem[idx] <= {gw, ga};
    end
    if (do_text) begin
      rd_data <= mem[idx];
    end
  end

  // valid bits and the space glyph copy used by tab
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      space_valid <= 1'b0;
      rd_hit      <= 1'b0;
    end else begin
      if (do_load && in_range) begin
        valid[idx] <= 1'b1;
      end
      if (do_load && (code == CODE_SPACE)) begin
        space_valid <= 1'b1;
      end
      if (do_text) begin
        rd_hit <= in_range && valid[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load && (code == CODE_SPACE)) begin
      space_width <= gw;
    end
  end

  // staging register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (do_text) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_text) begin
      s1_kind        <= kind;
      s1_last        <= s_tlast;
      s1_space_ok    <= space_valid && (space_width != '0);
      s1_space_width <= space_width;
    end
  end

  assign push_valid              = s1_valid;
  assign push_item.kind          = s1_kind;
  assign push_item.last          = s1_last;
  assign push_item.hit           = rd_hit;
  assign push_item.glyph_width   = rd_data[GLYPH_W_BITS +: GLYPH_W_BITS];
  assign push_item.glyph_advance = rd_data[GLYPH_W_BITS-1:0];
  assign push_item.space_ok      = s1_space_ok;
  assign push_item.space_width   = s1_space_width;

endmodule

// ----- rtl/core/twm_queue.sv -----
// short queue of classified text words between front and back
module twm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  twm_pkg::item_t push_item,
  output logic           push_ready,
  output logic           q_valid,
  output twm_pkg::item_t q_item,
  input  logic           pop
);
  import twm_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t                slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [FILL_BITS-1:0] fill;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (fill != FILL_BITS'(QUEUE_DEPTH));
  assign q_valid    = (fill != '0);
  assign q_item     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && q_valid;

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/twm_back.sv -----
// back end: line width engine, tab stop divider, scaling and result register
module twm_back #(
  parameter int TAB_SPACES  = twm_pkg::DEF_TAB_SPACES,
  parameter int ESCAPE_SKIP = twm_pkg::DEF_ESCAPE_SKIP,
  parameter int WIDTH_BITS  = twm_pkg::DEF_WIDTH_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [twm_pkg::SCALE_BITS-1:0]  width_scale,
  input  logic [twm_pkg::COUNT_BITS-1:0]  max_chars,
  input  logic                            q_valid,
  input  twm_pkg::item_t                  q_item,
  output logic                            pop,
  output logic                            res_valid,
  output twm_pkg::result_t                res,
  input  logic                            res_ready
);
  import twm_pkg::*;

  localparam int W         = WIDTH_BITS;
  localparam int SUM_BITS  = W + 2;
  localparam int STOP_BITS = GLYPH_W_BITS + $clog2(TAB_SPACES + 1);
  localparam int SKIP_BITS = $clog2(ESCAPE_SKIP + 1);
  localparam int CNT_BITS  = $clog2(W + 1);
  localparam int PROD_BITS = W + SCALE_BITS;
  localparam logic [W-1:0] WMAX = {W{1'b1}};

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_TAB  = 6'b000100,
    ST_FIN  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t                 state, state_next;
  logic [W-1:0]           line, line_next;
  logic [W-1:0]           longest, longest_next;
  logic [COUNT_BITS-1:0]  count, count_next;
  logic [SKIP_BITS-1:0]   skip, skip_next;
  logic                   discarding, discarding_next;
  logic                   sat_seen, sat_seen_next;
  logic                   pend_limit, pend_limit_next;
  logic                   pend_end, pend_end_next;
  logic [CNT_BITS-1:0]    div_cnt, div_cnt_next;
  logic [W-1:0]           div_dvd, div_dvd_next;
  logic [STOP_BITS-1:0]   div_rem, div_rem_next;
  logic [STOP_BITS-1:0]   stop, stop_next;
  logic [W-1:0]           w_emit, w_emit_next;
  logic                   emit_limit, emit_limit_next;
  logic                   emit_sat, emit_sat_next;
  logic [PROD_BITS-1:0]   prod;
  logic                   load_out;

  logic                   end_flag;
  logic                   lim;
  logic                   go_div;
  logic [SUM_BITS-1:0]    sum;
  logic [SUM_BITS-1:0]    nxt;
  logic [STOP_BITS:0]     trial;
  logic [63:0]            w_wide;
  logic [63:0]            prod_wide;

  // sequencer and per-string state update
  always_comb begin
    state_next      = state;
    line_next       = line;
    longest_next    = longest;
    count_next      = count;
    skip_next       = skip;
    discarding_next = discarding;
    sat_seen_next   = sat_seen;
    pend_limit_next = pend_limit;
    pend_end_next   = pend_end;
    div_cnt_next    = div_cnt;
    div_dvd_next    = div_dvd;
    div_rem_next    = div_rem;
    stop_next       = stop;
    w_emit_next     = w_emit;
    emit_limit_next = emit_limit;
    emit_sat_next   = emit_sat;
    pop             = 1'b0;
    load_out        = 1'b0;
    end_flag        = 1'b0;
    lim             = 1'b0;
    go_div          = 1'b0;
    sum             = '0;
    nxt             = '0;
    trial           = '0;

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          end_flag = (q_item.kind == KIND_END) || q_item.last;
          if (discarding) begin
            // rest of a string cut at the limit: wait for its end
            if (end_flag) begin
              line_next       = '0;
              longest_next    = '0;
              count_next      = '0;
              skip_next       = '0;
              discarding_next = 1'b0;
              sat_seen_next   = 1'b0;
            end
          end else begin
            if (q_item.kind != KIND_END) begin
              if (skip != '0) begin
                skip_next = skip - 1'b1;
              end else begin
                unique case (q_item.kind)
                  KIND_ESC: skip_next = SKIP_BITS'(ESCAPE_SKIP);
                  KIND_TAB: begin
                    if (q_item.space_ok) begin
                      go_div       = 1'b1;
                      div_dvd_next = line;
                      div_rem_next = '0;
                      div_cnt_next = CNT_BITS'(W);
                      stop_next    = STOP_BITS'(q_item.space_width * TAB_SPACES);
                    end
                  end
                  KIND_NL: begin
                    if (line > longest) begin
                      longest_next = line;
                    end
                    line_next = '0;
                  end
                  KIND_CHAR: begin
                    if (q_item.hit) begin
                      sum = SUM_BITS'(line) + SUM_BITS'(q_item.glyph_width)
                          + {{(SUM_BITS-GLYPH_W_BITS){q_item.glyph_advance[GLYPH_W_BITS-1]}},
                             q_item.glyph_advance};
                      if (sum[SUM_BITS-1]) begin
                        line_next     = '0;
                        sat_seen_next = 1'b1;
                      end else if (sum[W]) begin
                        line_next     = WMAX;
                        sat_seen_next = 1'b1;
                      end else begin
                        line_next = sum[W-1:0];
                      end
                    end
                  end
                  default: ;
                endcase
                count_next = count + 1'b1;
                lim        = (max_chars != '0) && (count_next == max_chars);
              end
            end
            pend_limit_next = lim;
            pend_end_next   = end_flag;
            if (go_div) begin
              state_next = ST_DIV;
            end else if (lim || end_flag) begin
              state_next = ST_FIN;
            end
          end
        end
      end

      // restoring division, one quotient bit a cycle, keeps the remainder
      ST_DIV: begin
        trial = {div_rem, div_dvd[W-1]};
        if (trial >= {1'b0, stop}) begin
          div_rem_next = STOP_BITS'(trial - {1'b0, stop});
        end else begin
          div_rem_next = trial[STOP_BITS-1:0];
        end
        div_dvd_next = {div_dvd[W-2:0], 1'b0};
        div_cnt_next = div_cnt - 1'b1;
        if (div_cnt == CNT_BITS'(1)) begin
          state_next = ST_TAB;
        end
      end

      // next tab stop is line minus remainder plus stop
      ST_TAB: begin
        nxt = SUM_BITS'(line) - SUM_BITS'(div_rem) + SUM_BITS'(stop);
        if (nxt[SUM_BITS-1:W] != '0) begin
          line_next     = WMAX;
          sat_seen_next = 1'b1;
        end else begin
          line_next = nxt[W-1:0];
        end
        state_next = (pend_limit || pend_end) ? ST_FIN : ST_IDLE;
      end

      // capture the result, then close or cut the string
      ST_FIN: begin
        w_emit_next     = (longest > line) ? longest : line;
        emit_limit_next = pend_limit;
        emit_sat_next   = sat_seen;
        if (pend_end) begin
          line_next       = '0;
          longest_next    = '0;
          count_next      = '0;
          skip_next       = '0;
          discarding_next = 1'b0;
          sat_seen_next   = 1'b0;
        end else begin
          discarding_next = 1'b1;
        end
        state_next = ST_MUL;
      end

      ST_MUL: state_next = ST_OUT;

      ST_OUT: begin
        if (!res_valid || res_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // control and string state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      line       <= '0;
      longest    <= '0;
      count      <= '0;
      skip       <= '0;
      discarding <= 1'b0;
      sat_seen   <= 1'b0;
      pend_limit <= 1'b0;
      pend_end   <= 1'b0;
      div_cnt    <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      line       <= line_next;
      longest    <= longest_next;
      count      <= count_next;
      skip       <= skip_next;
      discarding <= discarding_next;
      sat_seen   <= sat_seen_next;
      pend_limit <= pend_limit_next;
      pend_end   <= pend_end_next;
      div_cnt    <= div_cnt_next;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    div_dvd    <= div_dvd_next;
    div_rem    <= div_rem_next;
    stop       <= stop_next;
    w_emit     <= w_emit_next;
    emit_limit <= emit_limit_next;
    emit_sat   <= emit_sat_next;
    if (state == ST_MUL) begin
      prod <= PROD_BITS'(w_emit) * PROD_BITS'(width_scale);
    end
  end

  // output saturation and result register
  assign w_wide    = 64'(w_emit);
  assign prod_wide = 64'(prod);

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.width_units  <= (w_wide > 64'(UNITS_MAX)) ? UNITS_MAX : w_wide[UNITS_BITS-1:0];
      res.width_scaled <= (prod_wide > 64'(SCALED_MAX)) ? SCALED_MAX
                                                        : prod_wide[SCALED_BITS-1:0];
      res.limit_hit    <= emit_limit;
      res.saturated    <= emit_sat;
    end
  end

endmodule

// ----- rtl/core/twm_checker.sv -----
// port-level checks of the text width measurement block, bound to the top level
`include "text_width_measure_defines.svh"

module twm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [twm_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  input logic [twm_pkg::OUT_USER_BITS-1:0]  m_tuser
);
  import twm_pkg::*;

  // a stalled result word holds
  `TWM_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

  // no result straight out of reset
  `TWM_ASSERT_IMPL(a_quiet_after_reset, $past(rst), !m_tvalid, "result word right after reset")

  // zero width can only scale to zero
  `TWM_ASSERT_IMPL(a_zero_scales_zero, m_tvalid && (m_tdata[UNITS_BITS-1:0] == '0), m_tdata[OUT_DATA_BITS-1:UNITS_BITS] == '0, "nonzero scaled width for zero width")

endmodule

bind text_width_measure twm_checker u_checker (.*);

// ----- verif/twm_width_monitor.sv -----
// width predictor and result word compare for the text width measurement testbench
module twm_width_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [twm_pkg::IN_DATA_BITS-1:0]    s_tdata,   // code, glyph_width, glyph_advance
  input  logic                                s_tuser,   // cmd
  input  logic                                s_tlast,   // last
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [twm_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // width_units, width_scaled
  input  logic [twm_pkg::OUT_USER_BITS-1:0]   m_tuser,   // limit_hit, saturated
  input  logic                                cfg_we,
  input  logic [twm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [twm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  results_seen
);
  import twm_pkg::*;

  localparam int         TABLE_SIZE = DEF_TABLE_ENTRIES;
  localparam logic [2:0] SKIP_COUNT = 3'(DEF_ESCAPE_SKIP);
  localparam longint     LINE_MAX   = (longint'(1) << DEF_WIDTH_BITS) - 1;

  // glyph table copy, advance kept as two's complement
  logic                    glyph_ok  [TABLE_SIZE];
  logic [GLYPH_W_BITS-1:0] glyph_wid [TABLE_SIZE];
  logic [GLYPH_W_BITS-1:0] glyph_adv [TABLE_SIZE];

  logic [SCALE_BITS-1:0]   scale_reg;
  logic [COUNT_BITS-1:0]   limit_reg;

  // per-string measurement state
  logic [UNITS_BITS-1:0]   line_w;
  logic [UNITS_BITS-1:0]   longest_w;
  logic [COUNT_BITS-1:0]   chars_seen;
  logic [2:0]              skip_left;
  logic                    discarding;
  logic                    sat_seen;

  result_t                 want_q[$];
  int                      bad_count  = 0;
  int                      good_count = 0;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  task automatic restart_string();
    line_w     = '0;
    longest_w  = '0;
    chars_seen = '0;
    skip_left  = '0;
    discarding = 1'b0;
    sat_seen   = 1'b0;
  endtask

  task automatic clear_all();
    for (int k = 0; k < TABLE_SIZE; k++) begin
      glyph_ok[k]  = 1'b0;
      glyph_wid[k] = '0;
      glyph_adv[k] = '0;
    end
    scale_reg = SCALE_RESET;
    limit_reg = '0;
    want_q.delete();
    restart_string();
  endtask

  // clamp a new line width into the unsigned line range
  task automatic clamp_line(input longint v);
    if (v < 0) begin
      line_w   = '0;
      sat_seen = 1'b1;
    end else if (v > LINE_MAX) begin
      line_w   = UNITS_MAX;
      sat_seen = 1'b1;
    end else begin
      line_w = v[UNITS_BITS-1:0];
    end
  endtask

  // effect of one counted text byte on the line
  task automatic advance_line(input logic [CODE_BITS-1:0] code);
    longint stop;
    longint next;
    case (code)
      CODE_ESC: skip_left = SKIP_COUNT;
      CODE_TAB: begin
        if (glyph_ok[CODE_SPACE] && glyph_wid[CODE_SPACE] != '0) begin
          stop = longint'(glyph_wid[CODE_SPACE]) * DEF_TAB_SPACES;
          next = (longint'(line_w) / stop) * stop + stop;
          if (next > LINE_MAX) begin
            line_w   = UNITS_MAX;
            sat_seen = 1'b1;
          end else begin
            line_w = next[UNITS_BITS-1:0];
          end
        end
      end
      CODE_NL: begin
        if (line_w > longest_w) longest_w = line_w;
        line_w = '0;
      end
      default: begin
        if (glyph_ok[code])
          clamp_line(longint'(line_w) + longint'(glyph_wid[code])
                     + longint'($signed(glyph_adv[code])));
      end
    endcase
  endtask

  task automatic post_result(input logic at_limit);
    result_t               r;
    logic [UNITS_BITS-1:0] w;
    w              = (longest_w > line_w) ? longest_w : line_w;
    r.width_units  = w;
    r.width_scaled = {32'd0, w} * {24'd0, scale_reg};
    r.limit_hit    = at_limit;
    r.saturated    = sat_seen;
    want_q.push_back(r);
  endtask

  // one accepted input word
  task automatic take_word(input logic cmd, input logic [CODE_BITS-1:0] code,
                           input logic [GLYPH_W_BITS-1:0] gw,
                           input logic [GLYPH_W_BITS-1:0] ga, input logic last);
    logic ended;
    logic at_limit;
    ended    = (code == CODE_END) || last;
    at_limit = 1'b0;
    if (cmd == CMD_LOAD) begin
      glyph_ok[code]  = 1'b1;
      glyph_wid[code] = gw;
      glyph_adv[code] = ga;
    end else if (discarding) begin
      if (ended) restart_string();
    end else begin
      if (code != CODE_END) begin
        if (skip_left != '0) begin
          skip_left = skip_left - 3'd1;
        end else begin
          advance_line(code);
          chars_seen = chars_seen + 1'b1;
          at_limit   = (limit_reg != '0) && (chars_seen == limit_reg);
        end
      end
      if (at_limit || ended) begin
        post_result(at_limit);
        if (ended) restart_string();
        else discarding = 1'b1;
      end
    end
  endtask

  // compare one accepted result word with the oldest prediction
  task automatic check_result();
    result_t got;
    result_t exp;
    got.width_units  = m_tdata[UNITS_BITS-1:0];
    got.width_scaled = m_tdata[UNITS_BITS +: SCALED_BITS];
    got.limit_hit    = m_tuser[0];
    got.saturated    = m_tuser[1];
    good_count++;
    if (want_q.size() == 0) begin
      if (bad_count < 10)
        $display("unexpected result word: units %0d scaled %0h limit %0b sat %0b",
                 got.width_units, got.width_scaled, got.limit_hit, got.saturated);
      bad_count++;
    end else begin
      exp = want_q.pop_front();
      if (got.width_units !== exp.width_units || got.width_scaled !== exp.width_scaled ||
          got.limit_hit !== exp.limit_hit || got.saturated !== exp.saturated) begin
        if (bad_count < 10) begin
          $display("result %0d mismatch (exp/got): units %0d/%0d scaled %0h/%0h",
                   good_count, exp.width_units, got.width_units,
                   exp.width_scaled, got.width_scaled);
          $display("  limit %0b/%0b sat %0b/%0b", exp.limit_hit, got.limit_hit,
                   exp.saturated, got.saturated);
        end
        bad_count++;
      end
    end
  endtask

  // results first, then register writes, then the input word
  always @(posedge clk) begin
    if (rst) begin
      clear_all();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH_SCALE: scale_reg = cfg_wdata;
          REG_MAX_CHARS:   limit_reg = cfg_wdata[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        take_word(s_tuser, s_tdata[7:0], s_tdata[19:8], s_tdata[31:20], s_tlast);
    end
    mismatches   <= bad_count;
    outstanding  <= want_q.size();
    results_seen <= good_count;
  end

endmodule

// ----- verif/tb_text_width_measure.sv -----
// stimulus, clock, reset and verdict for the text width measurement block
module tb_text_width_measure;
  import twm_pkg::*;

  localparam int IDLE_PCT    = 27;
  localparam int SETTLE      = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 45;
  localparam int TAB_RUN     = 40;

  localparam logic [CODE_BITS-1:0] GL_WIDE   = 8'h41;
  localparam logic [CODE_BITS-1:0] GL_BACK   = 8'h42;
  localparam logic [CODE_BITS-1:0] GL_NARROW = 8'h43;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [IN_DATA_BITS-1:0]   s_tdata   = '0;   // code, glyph_width, glyph_advance
  logic                      s_tuser   = CMD_LOAD;   // cmd
  logic                      s_tlast   = 1'b0;   // last
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_tdata;   // width_units, width_scaled
  logic [OUT_USER_BITS-1:0]  m_tuser;   // limit_hit, saturated
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_WIDTH_SCALE;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int results_seen;
  int cycles     = 0;
  int words_sent = 0;
  int reg_writes = 0;

  logic                 quiet = 1'b0;
  logic [CODE_BITS-1:0] alphabet [6];

  text_width_measure DUT (.*);

  twm_width_monitor u_monitor (.*);

  always #1 clk = ~clk;

  // result side backpressure
  always @(posedge clk) m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("text_width_measure regression: fail");
      $finish;
    end
  end

  task automatic send_word(input logic cmd, input logic [CODE_BITS-1:0] code,
                           input logic [GLYPH_W_BITS-1:0] gw,
                           input logic [GLYPH_W_BITS-1:0] ga, input logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {ga, gw, code};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // text word with junk in the unused glyph fields
  task automatic send_text(input logic [CODE_BITS-1:0] code, input logic last);
    logic [31:0] junk;
    junk = $urandom;
    send_word(CMD_TEXT, code, junk[11:0], junk[23:12], last);
  endtask

  task automatic load_glyph(input logic [CODE_BITS-1:0] code,
                            input logic [GLYPH_W_BITS-1:0] gw,
                            input logic [GLYPH_W_BITS-1:0] ga);
    send_word(CMD_LOAD, code, gw, ga, 1'b0);
  endtask

  // wait until every predicted result has come and the block has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // mostly narrow glyphs, sometimes any bit pattern
  task automatic random_load(input logic [CODE_BITS-1:0] code);
    logic [31:0] r;
    r = $urandom;
    if (r[31:30] == 2'b00) load_glyph(code, r[11:0], r[23:12]);
    else load_glyph(code, {4'd0, r[7:0]}, {{7{r[16]}}, r[16:12]});
  endtask

  function automatic logic [CODE_BITS-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 50) return alphabet[$urandom_range(5)];
    else if (r < 62) return CODE_SPACE;
    else if (r < 71) return CODE_TAB;
    else if (r < 79) return CODE_NL;
    else if (r < 86) return CODE_ESC;
    else return 8'($urandom_range(255, 1));
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(4))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return SCALE_RESET;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(5))
      3:       return {28'd0, r[3:0]};
      4:       return 32'h0000_FFFF;
      5:       return {16'd0, r[15:0]};
      default: return 32'd0;
    endcase
  endfunction

  // one string of random content, with the odd stray word mixed in
  task automatic random_string(inout int count);
    int          len;
    logic [31:0] r;
    logic [31:0] q;
    len = $urandom_range(12, 1);
    for (int i = 0; i < len; i++) begin
      r = $urandom;
      q = $urandom;
      if (r[6:0] < 7'd9) send_word(r[7], r[15:8], q[11:0], q[23:12], r[16]);
      else if (i < len - 1) send_text(pick_char(), 1'b0);
      else if (r[8]) send_text(CODE_END, r[9]);
      else send_text(pick_char(), 1'b1);
      count++;
    end
  endtask

  initial begin
    int sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table: glyphs add nothing and tab has no space glyph
    send_text(GL_WIDE, 1'b0);
    send_text(CODE_TAB, 1'b0);
    send_text(CODE_END, 1'b0);
    // zero width space keeps tab still
    load_glyph(CODE_SPACE, 12'd0, 12'd0);
    send_text(CODE_TAB, 1'b1);
    load_glyph(GL_WIDE, 12'hFFF, 12'h7FF);
    load_glyph(GL_BACK, 12'h000, 12'h800);
    load_glyph(GL_NARROW, 12'd100, 12'hFFD);
    load_glyph(CODE_SPACE, 12'd7, 12'd1);
    // clamp at zero, newline, skipped colour code, tab stop
    send_text(GL_BACK, 1'b0);
    send_text(GL_NARROW, 1'b0);
    send_text(CODE_NL, 1'b0);
    send_text(GL_WIDE, 1'b0);
    send_text(CODE_ESC, 1'b0);
    repeat (4) send_text(GL_WIDE, 1'b0);
    send_text(CODE_TAB, 1'b0);
    send_text(GL_NARROW, 1'b1);
    // string ends inside a colour code
    send_text(CODE_ESC, 1'b0);
    send_text(GL_WIDE, 1'b1);

    // character limit with the rest discarded, then limit on the final byte
    drain();
    write_reg(REG_WIDTH_SCALE, 32'd0);
    write_reg(REG_MAX_CHARS, 32'd3);
    repeat (3) send_text(GL_NARROW, 1'b0);
    send_text(GL_WIDE, 1'b0);
    send_text(CODE_END, 1'b0);
    repeat (2) send_text(GL_NARROW, 1'b0);
    send_text(GL_NARROW, 1'b1);

    // tab run at the widest tab stop under full scale
    drain();
    write_reg(REG_WIDTH_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_MAX_CHARS, 32'h0000_FFFF);
    load_glyph(CODE_SPACE, 12'hFFF, 12'd0);
    repeat (TAB_RUN) send_text(CODE_TAB, 1'b0);
    send_text(GL_WIDE, 1'b1);

    // limit raised mid-string above the count, then set below it
    drain();
    write_reg(REG_WIDTH_SCALE, SCALE_RESET);
    write_reg(REG_MAX_CHARS, 32'd0);
    repeat (5) send_text(GL_NARROW, 1'b0);
    drain();
    write_reg(REG_MAX_CHARS, 32'd7);
    repeat (2) send_text(GL_NARROW, 1'b0);
    send_text(GL_NARROW, 1'b1);
    drain();
    write_reg(REG_MAX_CHARS, 32'd0);
    repeat (5) send_text(GL_NARROW, 1'b0);
    drain();
    write_reg(REG_MAX_CHARS, 32'd2);
    send_text(GL_NARROW, 1'b0);
    send_text(GL_NARROW, 1'b1);

    // random phases, each with its own settings and glyph set
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      quiet <= (ph == 3);
      write_reg(REG_WIDTH_SCALE, pick_scale());
      write_reg(REG_MAX_CHARS, pick_limit());
      for (int k = 0; k < 6; k++) begin
        alphabet[k] = 8'($urandom_range(255, 33));
        random_load(alphabet[k]);
      end
      if ($urandom_range(3) == 0) load_glyph(CODE_SPACE, 12'd0, 12'd0);
      else random_load(CODE_SPACE);
      sent = 0;
      while (sent < PHASE_WORDS) random_string(sent);
    end

    drain();
    $display("sent %0d words under %0d register writes, checked %0d result words",
             words_sent, reg_writes, results_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("text_width_measure regression: pass");
    end else begin
      $display("text_width_measure regression: fail");
    end
    $finish;
  end

endmodule
